### design/tcfsm_pkg.sv
// types, codes and constants shared by the tcp client connection engine
`timescale 1ns / 1ps

package tcfsm_pkg;

   localparam int unsigned RX_BUFFER_BYTES = 8192;
   localparam int unsigned RX_FILL_W       = $clog2(RX_BUFFER_BYTES + 1);
   localparam logic [15:0] FIRST_PORT      = 16'd49152;
   localparam logic [15:0] MIN_HEADER      = 16'd20;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_PSH = 8'h08;
   localparam logic [7:0] FL_ACK = 8'h10;

   typedef enum logic [2:0] {
      MODE_CONNECT = 3'd0,
      MODE_SEND    = 3'd1,
      MODE_CLOSE   = 3'd2,
      MODE_TIMEOUT = 3'd3,
      MODE_CONSUME = 3'd4,
      MODE_SEGMENT = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLOSED      = 3'd0,
      ST_SYN_SENT    = 3'd1,
      ST_ESTABLISHED = 3'd2,
      ST_CLOSE_WAIT  = 3'd3,
      ST_FIN_WAIT    = 3'd4
   } link_state_type;

   // request tdata layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic [15:0] item_length;
      logic [7:0]  segment_flags;
      logic [3:0]  header_words;
      logic [31:0] seq_value;
      logic [15:0] segment_dst_port;
      logic [15:0] peer_port;
      logic [31:0] peer_ip;
   } item_type;

   typedef struct packed {
      mode_type mode;
      item_type item;
   } event_type;

   // response tdata layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic [15:0] taken_bytes;
      logic        status;
      logic [2:0]  conn_state;
      logic [31:0] out_peer_ip;
      logic [15:0] out_dst_port;
      logic [15:0] out_src_port;
      logic [31:0] out_ack;
      logic [31:0] out_seq;
      logic [7:0]  out_flags;
   } rsp_body_type;

   typedef struct packed {
      logic         emit_segment;
      rsp_body_type body;
   } result_type;

endpackage

### design/tcp_client_connection_fsm_unit.sv
// top level of the single-connection tcp client engine with stream handshakes
`timescale 1ns / 1ps

// channel | direction | tdata                         | tuser
// req     | in        | 128 bits, event fields        | 3 bits, mode
// rsp     | out       | 160 bits, header and status   | 1 bit, emit_segment
//
// one event per clock while rsp is not stalled; a req transfer loads the event register, then the result register
// the event register feeds the engine, the result register holds its answer
// connection state updates as an event moves into the result register
// reset clears both valid flags and all connection state
// while rsp is stalled one more event is held in the event register

module tcp_client_connection_fsm_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // peer_ip, peer_port, segment_dst_port, seq_value, header_words,
   // segment_flags, item_length, zero pad
   input  logic [127:0] req_tdata,
   // mode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_flags, out_seq, out_ack, out_src_port, out_dst_port, out_peer_ip,
   // conn_state, status, taken_bytes, zero pad
   output logic [159:0] rsp_tdata,
   // emit_segment
   output logic [0:0]   rsp_tuser
);

   logic                  evt_valid_ff, evt_valid_in;
   tcfsm_pkg::event_type  evt_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   tcfsm_pkg::result_type rsp_ff;
   tcfsm_pkg::result_type result;
   logic                  advance;
   logic                  req_xfer;

   assign advance      = evt_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !evt_valid_ff || advance;
   assign req_xfer     = req_tvalid && req_tready;
   assign evt_valid_in = req_xfer || (evt_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         evt_ff.mode <= tcfsm_pkg::mode_type'(req_tuser);
         evt_ff.item <= tcfsm_pkg::item_type'(req_tdata);
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   tcfsm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .evt    (evt_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.body;
   assign rsp_tuser  = rsp_ff.emit_segment;

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> evt_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled while a register was free");

endmodule

### design/tcfsm_engine.sv
// connection state registers and the per-event next state and result logic
`timescale 1ns / 1ps

module tcfsm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tcfsm_pkg::event_type  evt,
   output tcfsm_pkg::result_type result
);

   tcfsm_pkg::link_state_type link_state_ff, link_state_in;
   logic                                active_ff, active_in;
   logic [15:0]                         next_port_ff, next_port_in;
   logic [15:0]                         local_port_ff, local_port_in;
   logic [31:0]                         remote_ip_ff, remote_ip_in;
   logic [15:0]                         remote_port_ff, remote_port_in;
   logic [31:0]                         send_seq_ff, send_seq_in;
   logic [31:0]                         recv_ack_ff, recv_ack_in;
   logic [tcfsm_pkg::RX_FILL_W-1:0]     rx_fill_ff, rx_fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff  <= tcfsm_pkg::ST_CLOSED;
         active_ff      <= 1'b0;
         next_port_ff   <= tcfsm_pkg::FIRST_PORT;
         local_port_ff  <= '0;
         remote_ip_ff   <= '0;
         remote_port_ff <= '0;
         send_seq_ff    <= '0;
         recv_ack_ff    <= '0;
         rx_fill_ff     <= '0;
      end else if (step) begin
         link_state_ff  <= link_state_in;
         active_ff      <= active_in;
         next_port_ff   <= next_port_in;
         local_port_ff  <= local_port_in;
         remote_ip_ff   <= remote_ip_in;
         remote_port_ff <= remote_port_in;
         send_seq_ff    <= send_seq_in;
         recv_ack_ff    <= recv_ack_in;
         rx_fill_ff     <= rx_fill_in;
      end
   end

   logic        ok;
   logic        emit;
   logic [7:0]  hdr_flags;
   logic [15:0] taken;
   logic        hdr_old_seq;
   logic [5:0]  off;
   logic [15:0] plen;
   logic [16:0] fill_sum;
   logic [15:0] fill_ext;
   logic [15:0] grab;
   logic        seg_match;

   always_comb begin
      link_state_in  = link_state_ff;
      active_in      = active_ff;
      next_port_in   = next_port_ff;
      local_port_in  = local_port_ff;
      remote_ip_in   = remote_ip_ff;
      remote_port_in = remote_port_ff;
      send_seq_in    = send_seq_ff;
      recv_ack_in    = recv_ack_ff;
      rx_fill_in     = rx_fill_ff;
      ok             = 1'b0;
      emit           = 1'b0;
      hdr_flags      = '0;
      taken          = '0;
      hdr_old_seq    = 1'b0;

      off       = {evt.item.header_words, 2'b00};
      plen      = evt.item.item_length - 16'(off);
      fill_sum  = 17'(rx_fill_ff) + 17'(plen);
      fill_ext  = 16'(rx_fill_ff);
      grab      = (fill_ext < evt.item.item_length) ? fill_ext : evt.item.item_length;
      seg_match = (evt.item.item_length >= tcfsm_pkg::MIN_HEADER) && active_ff &&
                  (evt.item.peer_ip == remote_ip_ff) &&
                  (evt.item.peer_port == remote_port_ff) &&
                  (evt.item.segment_dst_port == local_port_ff);

      unique case (evt.mode)
         tcfsm_pkg::MODE_CONNECT: begin
            remote_ip_in   = evt.item.peer_ip;
            remote_port_in = evt.item.peer_port;
            local_port_in  = next_port_ff;
            next_port_in   = next_port_ff + 16'd1;
            send_seq_in    = evt.item.seq_value | 32'd1;
            recv_ack_in    = '0;
            rx_fill_in     = '0;
            link_state_in  = tcfsm_pkg::ST_SYN_SENT;
            active_in      = 1'b1;
            emit           = 1'b1;
            hdr_flags      = tcfsm_pkg::FL_SYN;
            ok             = 1'b1;
         end
         tcfsm_pkg::MODE_SEND: begin
            if (link_state_ff == tcfsm_pkg::ST_ESTABLISHED) begin
               emit        = 1'b1;
               hdr_flags   = tcfsm_pkg::FL_PSH | tcfsm_pkg::FL_ACK;
               hdr_old_seq = 1'b1;
               send_seq_in = send_seq_ff + 32'(evt.item.item_length);
               taken       = evt.item.item_length;
               ok          = 1'b1;
            end
         end
         tcfsm_pkg::MODE_CLOSE: begin
            ok = 1'b1;
            if (link_state_ff == tcfsm_pkg::ST_ESTABLISHED) begin
               link_state_in = tcfsm_pkg::ST_FIN_WAIT;
               emit          = 1'b1;
               hdr_flags     = tcfsm_pkg::FL_FIN | tcfsm_pkg::FL_ACK;
               hdr_old_seq   = 1'b1;
               send_seq_in   = send_seq_ff + 32'd1;
            end else begin
               link_state_in = tcfsm_pkg::ST_CLOSED;
               active_in     = 1'b0;
            end
         end
         tcfsm_pkg::MODE_TIMEOUT: begin
            if (link_state_ff == tcfsm_pkg::ST_SYN_SENT) begin
               link_state_in = tcfsm_pkg::ST_CLOSED;
               ok            = 1'b1;
            end else if (link_state_ff == tcfsm_pkg::ST_FIN_WAIT) begin
               link_state_in = tcfsm_pkg::ST_CLOSED;
               active_in     = 1'b0;
               ok            = 1'b1;
            end
         end
         tcfsm_pkg::MODE_CONSUME: begin
            if (grab != 16'd0) begin
               rx_fill_in = rx_fill_ff - grab[tcfsm_pkg::RX_FILL_W-1:0];
               taken      = grab;
               ok         = 1'b1;
            end
         end
         tcfsm_pkg::MODE_SEGMENT: begin
            if (seg_match) begin
               priority if ((evt.item.segment_flags & tcfsm_pkg::FL_RST) != 8'd0) begin
                  link_state_in = tcfsm_pkg::ST_CLOSED;
                  ok            = 1'b1;
               end else if (link_state_ff == tcfsm_pkg::ST_SYN_SENT) begin
                  if ((evt.item.segment_flags & (tcfsm_pkg::FL_SYN | tcfsm_pkg::FL_ACK)) ==
                      (tcfsm_pkg::FL_SYN | tcfsm_pkg::FL_ACK)) begin
                     recv_ack_in   = evt.item.seq_value + 32'd1;
                     send_seq_in   = send_seq_ff + 32'd1;
                     link_state_in = tcfsm_pkg::ST_ESTABLISHED;
                     emit          = 1'b1;
                     hdr_flags     = tcfsm_pkg::FL_ACK;
                     ok            = 1'b1;
                  end
               end else if (link_state_ff == tcfsm_pkg::ST_ESTABLISHED) begin
                  if ((evt.item.segment_flags & tcfsm_pkg::FL_FIN) != 8'd0) begin
                     recv_ack_in   = evt.item.seq_value + 32'd1;
                     link_state_in = tcfsm_pkg::ST_CLOSE_WAIT;
                     emit          = 1'b1;
                     hdr_flags     = tcfsm_pkg::FL_ACK;
                     ok            = 1'b1;
                  end else if ((16'(off) < evt.item.item_length) &&
                               (fill_sum <= 17'(tcfsm_pkg::RX_BUFFER_BYTES))) begin
                     rx_fill_in  = fill_sum[tcfsm_pkg::RX_FILL_W-1:0];
                     recv_ack_in = evt.item.seq_value + 32'(plen);
                     emit        = 1'b1;
                     hdr_flags   = tcfsm_pkg::FL_ACK;
                     taken       = plen;
                     ok          = 1'b1;
                  end
               end else if (link_state_ff == tcfsm_pkg::ST_FIN_WAIT) begin
                  if ((evt.item.segment_flags & tcfsm_pkg::FL_ACK) != 8'd0) begin
                     if ((evt.item.segment_flags & tcfsm_pkg::FL_FIN) != 8'd0) begin
                        recv_ack_in = evt.item.seq_value + 32'd1;
                        emit        = 1'b1;
                        hdr_flags   = tcfsm_pkg::FL_ACK;
                     end
                     link_state_in = tcfsm_pkg::ST_CLOSED;
                     active_in     = 1'b0;
                     ok            = 1'b1;
                  end
               end else begin
                  // closed after a timeout or a reset flag, or close wait: segment ignored
               end
            end
         end
         default: begin
         end
      endcase

      result                   = '0;
      result.emit_segment      = emit;
      result.body.conn_state   = link_state_in;
      result.body.status       = ~ok;
      result.body.taken_bytes  = taken;
      if (emit) begin
         result.body.out_flags    = hdr_flags;
         result.body.out_seq      = hdr_old_seq ? send_seq_ff : send_seq_in;
         result.body.out_ack      = recv_ack_in;
         result.body.out_src_port = local_port_in;
         result.body.out_dst_port = remote_port_in;
         result.body.out_peer_ip  = remote_ip_in;
      end
   end

   a_connect_syn_sent: assert property (@(posedge clock) disable iff (reset)
      step && evt.mode == tcfsm_pkg::MODE_CONNECT |=>
         link_state_ff == tcfsm_pkg::ST_SYN_SENT && active_ff)
      else $error("connect did not open the link");

   a_fill_limit: assert property (@(posedge clock) disable iff (reset)
      32'(rx_fill_ff) <= tcfsm_pkg::RX_BUFFER_BYTES)
      else $error("receive fill above buffer size");

   a_inactive_closed: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> link_state_ff == tcfsm_pkg::ST_CLOSED)
      else $error("inactive connection not closed");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(link_state_ff) && $stable(rx_fill_ff) && $stable(send_seq_ff))
      else $error("connection state moved without an event");

endmodule

### tb/tb_top.sv
// testbench for the tcp client connection engine: directed and random events checked per transfer
`timescale 1ns / 1ps

module tb_top;
   import tcfsm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   // connection as the engine should see it
   link_state_type link_st = ST_CLOSED;
   bit             conn_active = 1'b0;
   logic [15:0]    port_counter = FIRST_PORT;
   logic [15:0]    my_port = '0;
   logic [31:0]    peer_addr = '0;
   logic [15:0]    peer_prt = '0;
   logic [31:0]    tx_seq = '0;
   logic [31:0]    rx_ack = '0;
   int unsigned    rx_count = 0;

   result_type pending_answers[$];
   result_type got_answer;
   result_type want_answer;
   int         fails = 0;
   int         events_sent = 0;
   int         quiet_cycles = 0;
   int         src_idle_pct = 0;
   int         sink_stall_pct = 0;
   int         hold_asked = 0;
   int         hold_seen = 0;
   int         hold_left = 0;

   tcp_client_connection_fsm_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic result_type outgoing(input logic [7:0] flags);
      result_type r;
      r = '0;
      r.emit_segment      = 1'b1;
      r.body.out_flags    = flags;
      r.body.out_seq      = tx_seq;
      r.body.out_ack      = rx_ack;
      r.body.out_src_port = my_port;
      r.body.out_dst_port = peer_prt;
      r.body.out_peer_ip  = peer_addr;
      return r;
   endfunction

   function automatic result_type engine_response(input mode_type m, input item_type it);
      result_type  r;
      bit          ok;
      int unsigned n;
      int unsigned off;
      int unsigned plen;
      r  = '0;
      ok = 1'b0;
      case (m)
         MODE_CONNECT: begin
            peer_addr    = it.peer_ip;
            peer_prt     = it.peer_port;
            my_port      = port_counter;
            port_counter = port_counter + 16'd1;
            tx_seq       = it.seq_value | 32'd1;
            rx_ack       = '0;
            rx_count     = 0;
            link_st      = ST_SYN_SENT;
            conn_active  = 1'b1;
            r  = outgoing(FL_SYN);
            ok = 1'b1;
         end
         MODE_SEND: begin
            if (link_st == ST_ESTABLISHED) begin
               r = outgoing(FL_PSH | FL_ACK);
               tx_seq = tx_seq + it.item_length;
               r.body.taken_bytes = it.item_length;
               ok = 1'b1;
            end
         end
         MODE_CLOSE: begin
            if (link_st == ST_ESTABLISHED) begin
               link_st = ST_FIN_WAIT;
               r = outgoing(FL_FIN | FL_ACK);
               tx_seq = tx_seq + 32'd1;
            end else begin
               link_st = ST_CLOSED;
               conn_active = 1'b0;
            end
            ok = 1'b1;
         end
         MODE_TIMEOUT: begin
            if (link_st == ST_SYN_SENT) begin
               link_st = ST_CLOSED;
               ok = 1'b1;
            end else if (link_st == ST_FIN_WAIT) begin
               link_st = ST_CLOSED;
               conn_active = 1'b0;
               ok = 1'b1;
            end
         end
         MODE_CONSUME: begin
            n = (rx_count < it.item_length) ? rx_count : it.item_length;
            if (n > 0) begin
               rx_count = rx_count - n;
               r.body.taken_bytes = n[15:0];
               ok = 1'b1;
            end
         end
         MODE_SEGMENT: begin
            off = it.header_words * 4;
            if (it.item_length >= MIN_HEADER && conn_active && it.peer_ip == peer_addr &&
                it.peer_port == peer_prt && it.segment_dst_port == my_port) begin
               if ((it.segment_flags & FL_RST) != 0) begin
                  link_st = ST_CLOSED;
                  ok = 1'b1;
               end else if (link_st == ST_SYN_SENT) begin
                  if ((it.segment_flags & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK)) begin
                     rx_ack  = it.seq_value + 32'd1;
                     tx_seq  = tx_seq + 32'd1;
                     link_st = ST_ESTABLISHED;
                     r  = outgoing(FL_ACK);
                     ok = 1'b1;
                  end
               end else if (link_st == ST_ESTABLISHED) begin
                  if ((it.segment_flags & FL_FIN) != 0) begin
                     rx_ack  = it.seq_value + 32'd1;
                     link_st = ST_CLOSE_WAIT;
                     r  = outgoing(FL_ACK);
                     ok = 1'b1;
                  end else if (off < it.item_length) begin
                     plen = it.item_length - off;
                     if (rx_count + plen <= RX_BUFFER_BYTES) begin
                        rx_count = rx_count + plen;
                        rx_ack   = it.seq_value + plen;
                        r = outgoing(FL_ACK);
                        r.body.taken_bytes = plen[15:0];
                        ok = 1'b1;
                     end
                  end
               end else if (link_st == ST_FIN_WAIT) begin
                  if ((it.segment_flags & FL_ACK) != 0) begin
                     if ((it.segment_flags & FL_FIN) != 0) begin
                        rx_ack = it.seq_value + 32'd1;
                        r = outgoing(FL_ACK);
                     end
                     link_st = ST_CLOSED;
                     conn_active = 1'b0;
                     ok = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.body.conn_state = link_st;
      r.body.status     = ~ok;
      return r;
   endfunction

   function automatic item_type any_item();
      item_type it;
      it.pad              = '0;
      it.peer_ip          = $urandom;
      it.peer_port        = 16'($urandom);
      it.segment_dst_port = 16'($urandom);
      it.seq_value        = $urandom;
      it.header_words     = 4'($urandom);
      it.segment_flags    = 8'($urandom);
      it.item_length      = 16'($urandom);
      return it;
   endfunction

   function automatic logic [15:0] some_length();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
         default: return 16'($urandom_range(600));
      endcase
   endfunction

   // segment that matches the open connection
   function automatic item_type peer_segment(input logic [7:0] flags, input logic [15:0] len);
      item_type it;
      it = any_item();
      it.peer_ip          = peer_addr;
      it.peer_port        = peer_prt;
      it.segment_dst_port = my_port;
      it.segment_flags    = flags;
      it.item_length      = len;
      it.header_words     = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15));
      return it;
   endfunction

   task automatic send_event(input mode_type m, input item_type it);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = it;
      req_tuser  = m;
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_answers.push_back(engine_response(m, it));
      events_sent++;
   endtask

   task automatic send_noise();
      item_type it;
      mode_type m;
      m  = mode_type'($urandom_range(5));
      it = any_item();
      if (m == MODE_SEGMENT && $urandom_range(1) == 0) begin
         it = peer_segment(8'($urandom), some_length());
         case ($urandom_range(3))
            0: it.peer_ip = it.peer_ip ^ (32'd1 << $urandom_range(31));
            1: it.peer_port = it.peer_port ^ (16'd1 << $urandom_range(15));
            2: it.segment_dst_port = it.segment_dst_port ^ (16'd1 << $urandom_range(15));
            default: it.item_length = 16'($urandom_range(19));
         endcase
      end
      send_event(m, it);
   endtask

   task automatic run_session();
      item_type    it;
      logic [7:0]  fl;
      logic [15:0] len;
      int          n_ops;
      send_event(MODE_CONNECT, any_item());
      case ($urandom_range(9))
         0: send_event(MODE_TIMEOUT, any_item());
         1: send_event(MODE_SEGMENT, peer_segment(8'($urandom) | FL_RST, some_length()));
         2: send_event(MODE_SEGMENT, peer_segment(8'($urandom) & ~FL_RST, some_length()));
         default: begin
            fl = 8'($urandom) & ~(FL_RST | FL_FIN) | FL_SYN | FL_ACK;
            send_event(MODE_SEGMENT, peer_segment(fl, 16'($urandom_range(20, 1500))));
         end
      endcase
      n_ops = $urandom_range(2, 20);
      repeat (n_ops) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               fl  = 8'($urandom) & ~(FL_RST | FL_FIN);
               len = ($urandom_range(7) == 0) ? some_length() : 16'(20 + $urandom_range(1400));
               send_event(MODE_SEGMENT, peer_segment(fl, len));
            end
            4, 5: begin
               it = any_item();
               it.item_length = some_length();
               send_event(MODE_SEND, it);
            end
            6, 7: begin
               it = any_item();
               it.item_length = ($urandom_range(1) == 0) ? some_length()
                                                        : 16'($urandom_range(4000));
               send_event(MODE_CONSUME, it);
            end
            default: send_noise();
         endcase
      end
      case ($urandom_range(5))
         0: begin
            send_event(MODE_SEGMENT,
                       peer_segment(8'($urandom) & ~FL_RST | FL_FIN, some_length() | 16'd20));
            if ($urandom_range(1) == 0) send_event(MODE_SEND, any_item());
            send_event(MODE_CLOSE, any_item());
         end
         1: begin
            send_event(MODE_CLOSE, any_item());
            send_event(MODE_SEGMENT,
                       peer_segment(8'($urandom) & ~FL_RST | FL_ACK, 16'($urandom_range(20, 80))));
         end
         2: begin
            send_event(MODE_CLOSE, any_item());
            send_event(MODE_TIMEOUT, any_item());
         end
         3: begin
            send_event(MODE_CLOSE, any_item());
            send_event(MODE_SEGMENT,
                       peer_segment(8'($urandom) & ~(FL_RST | FL_ACK), 16'd40));
            send_event(MODE_SEGMENT, peer_segment(FL_FIN | FL_ACK, 16'd20));
         end
         4: send_event(MODE_SEGMENT, peer_segment(FL_RST, 16'($urandom_range(20, 100))));
         default: ;
      endcase
   endtask

   task automatic test_directed();
      item_type it;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      it = any_item();
      it.item_length = 16'hFFFF;
      send_event(MODE_CONSUME, it);
      send_event(MODE_SEND, any_item());
      it = any_item();
      it.item_length = 16'd40;
      send_event(MODE_SEGMENT, it);
      send_event(MODE_CLOSE, any_item());
      it = any_item();
      it.peer_ip   = '1;
      it.peer_port = '1;
      it.seq_value = 32'hFFFF_FFFE;
      send_event(MODE_CONNECT, it);
      send_event(MODE_SEGMENT, peer_segment(FL_SYN | FL_ACK, 16'd19));
      it = peer_segment(FL_SYN | FL_ACK, 16'd40);
      it.peer_ip = it.peer_ip ^ 32'h8000_0000;
      send_event(MODE_SEGMENT, it);
      it = peer_segment(FL_SYN | FL_ACK, 16'd40);
      it.segment_dst_port = it.segment_dst_port ^ 16'h0001;
      send_event(MODE_SEGMENT, it);
      send_event(MODE_SEGMENT, peer_segment(FL_ACK, 16'd20));
      send_event(MODE_TIMEOUT, any_item());
      // reset flag still honored while active after a timeout
      send_event(MODE_SEGMENT, peer_segment(FL_RST | FL_ACK, 16'd20));
      it = any_item();
      it.peer_ip   = '0;
      it.peer_port = '0;
      it.seq_value = '0;
      send_event(MODE_CONNECT, it);
      it = peer_segment(FL_SYN | FL_ACK, 16'hFFFF);
      it.seq_value = '1;
      send_event(MODE_SEGMENT, it);
      // short data offset
      it = peer_segment(FL_ACK | FL_PSH, 16'd20);
      it.header_words = 4'd0;
      send_event(MODE_SEGMENT, it);
      it = peer_segment(FL_ACK, 16'd60);
      it.header_words = 4'd15;
      send_event(MODE_SEGMENT, it);
      // fill the buffer exactly, then overflow by one byte
      it = peer_segment(FL_ACK, 16'(RX_BUFFER_BYTES));
      it.header_words = 4'd5;
      send_event(MODE_SEGMENT, it);
      it = peer_segment(FL_ACK, 16'd21);
      it.header_words = 4'd5;
      send_event(MODE_SEGMENT, it);
      it = any_item();
      it.item_length = 16'hFFFF;
      send_event(MODE_CONSUME, it);
      it = any_item();
      it.item_length = 16'hFFFF;
      send_event(MODE_SEND, it);
      send_event(MODE_SEGMENT, peer_segment(FL_FIN | FL_ACK, 16'd20));
      send_event(MODE_SEGMENT, peer_segment(FL_ACK, 16'd100));
      send_event(MODE_CLOSE, any_item());
      send_event(MODE_CONNECT, any_item());
      send_event(MODE_SEGMENT, peer_segment(FL_SYN | FL_ACK, 16'd20));
      send_event(MODE_CLOSE, any_item());
      send_event(MODE_SEGMENT, peer_segment(FL_FIN | FL_ACK, 16'd20));
   endtask

   task automatic test_random(input int count, input int src_pct, input int sink_pct);
      int target;
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      target = events_sent + count;
      while (events_sent < target) begin
         if ($urandom_range(3) == 0) send_noise();
         else run_session();
      end
   endtask

   task automatic test_backpressure();
      int target;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_asked++;
      target = events_sent + 40;
      while (events_sent < target) run_session();
   endtask

   // result side: random stalls plus the long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else if (hold_seen != hold_asked) begin
         hold_seen  = hold_asked;
         hold_left  = HOLD_CYCLES;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= sink_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h got %0h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_answer = {rsp_tuser, rsp_tdata};
         if (pending_answers.size() == 0) begin
            $error("result transfer with no event pending");
            fails++;
         end else begin
            want_answer = pending_answers.pop_front();
            check_field("emit_segment", 32'(want_answer.emit_segment),
                        32'(got_answer.emit_segment));
            check_field("out_flags", 32'(want_answer.body.out_flags),
                        32'(got_answer.body.out_flags));
            check_field("out_seq", want_answer.body.out_seq, got_answer.body.out_seq);
            check_field("out_ack", want_answer.body.out_ack, got_answer.body.out_ack);
            check_field("out_src_port", 32'(want_answer.body.out_src_port),
                        32'(got_answer.body.out_src_port));
            check_field("out_dst_port", 32'(want_answer.body.out_dst_port),
                        32'(got_answer.body.out_dst_port));
            check_field("out_peer_ip", want_answer.body.out_peer_ip,
                        got_answer.body.out_peer_ip);
            check_field("conn_state", 32'(want_answer.body.conn_state),
                        32'(got_answer.body.conn_state));
            check_field("status", 32'(want_answer.body.status), 32'(got_answer.body.status));
            check_field("taken_bytes", 32'(want_answer.body.taken_bytes),
                        32'(got_answer.body.taken_bytes));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(450, 0, 0);
      test_random(450, 59, 0);
      test_random(450, 0, 59);
      test_random(400, 17, 17);
      test_backpressure();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0 && pending_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
